@@ rtl/core/crtm_pkg.sv @@
// Package with the shared types and constants of the congruence merge core.
package crtm_pkg;

  localparam int unsigned DataW = 64;
  localparam logic [DataW-1:0] Pow63 = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CRTM_ST_OK    = 2'd0,
    CRTM_ST_NOSOL = 2'd1,
    CRTM_ST_OVF   = 2'd2
  } crtm_status_e;

  typedef enum logic {
    CRTM_OP_DIV    = 1'b0,
    CRTM_OP_MULMOD = 1'b1
  } crtm_op_e;

  typedef enum logic [4:0] {
    CRTM_IDLE,
    CRTM_RED,
    CRTM_MOD0,
    CRTM_CHK0,
    CRTM_GCD,
    CRTM_DCALC,
    CRTM_DG,
    CRTM_U1,
    CRTM_LIM,
    CRTM_A0,
    CRTM_A1,
    CRTM_INVQ,
    CRTM_INVM,
    CRTM_DR,
    CRTM_TM,
    CRTM_RM,
    CRTM_M1,
    CRTM_OUT
  } crtm_state_e;

  typedef struct packed {
    logic             start;
    crtm_op_e         op;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] n;
  } crtm_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] rem;
  } crtm_rsp_t;

endpackage

@@ rtl/core/crtm_in_if.sv @@
// Input channel: one congruence word per handshake.
interface crtm_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] residue;
  logic [62:0]        modulus;
  logic               start_req;

  modport source (output valid, residue, modulus, start_req, input ready);
  modport sink (input valid, residue, modulus, start_req, output ready);
endinterface

@@ rtl/core/crtm_out_if.sv @@
// Output channel: one merged result word per handshake.
interface crtm_out_if;
  logic        valid;
  logic        ready;
  logic [62:0] merged_residue;
  logic [62:0] merged_modulus;
  logic [1:0]  status;

  modport source (output valid, merged_residue, merged_modulus, status, input ready);
  modport sink (input valid, merged_residue, merged_modulus, status, output ready);
endinterface

@@ rtl/core/crtm_alu.sv @@
// Shared arithmetic unit: bit-serial restoring divider and shift-add modular multiplier.
module crtm_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  crtm_pkg::crtm_req_t req_i,
  output crtm_pkg::crtm_rsp_t rsp_o
);

  localparam int unsigned W = crtm_pkg::DataW;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  crtm_pkg::crtm_op_e  op_q, op_d;
  logic [6:0]          cnt_q, cnt_d;
  logic [W-1:0]        x_q, x_d;
  logic [W-1:0]        y_q, y_d;
  logic [W-1:0]        n_q, n_d;
  logic [W:0]          acc_q, acc_d;
  logic [W-1:0]        quo_q, quo_d;

  logic [W:0] div_sh, add_s, dbl_s;
  logic       div_ge;

  always_comb begin
    div_sh = {acc_q[W-1:0], x_q[W-1]};
    div_ge = (div_sh >= {1'b0, y_q});
    add_s  = acc_q + {1'b0, x_q};
    dbl_s  = {x_q, 1'b0};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    n_d    = n_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      x_d    = req_i.a;
      y_d    = req_i.b;
      n_d    = req_i.n;
      acc_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      if (op_q == crtm_pkg::CRTM_OP_DIV) begin
        acc_d = div_ge ? (div_sh - {1'b0, y_q}) : div_sh;
        quo_d = {quo_q[W-2:0], div_ge};
        x_d   = {x_q[W-2:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(W - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        if (y_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          if (y_q[0]) begin
            acc_d = (add_s >= {1'b0, n_q}) ? (add_s - {1'b0, n_q}) : add_s;
          end
          x_d = (dbl_s >= {1'b0, n_q}) ? W'(dbl_s - {1'b0, n_q}) : dbl_s[W-1:0];
          y_d = {1'b0, y_q[W-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= crtm_pkg::CRTM_OP_DIV;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    n_q   <= n_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = acc_q[W-1:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q && !done_q)
    else $error("start issued while the unit is busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held for more than one cycle");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done while still busy");
  a_mul_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && op_q == crtm_pkg::CRTM_OP_MULMOD) |-> (acc_q < {1'b0, n_q}))
    else $error("modular product not reduced");

endmodule

@@ rtl/core/crt_congruence_merge_core.sv @@
// Top level: sequencer that merges congruences with the shared arithmetic unit.
//   channel  | dir | payload                                   | handshake
//   in_i     | in  | residue, modulus, start_req               | valid/ready
//   out_o    | out | merged_residue, merged_modulus, status    | valid/ready
// Every division and modular multiply of a word runs on the one shared unit; their
// number grows with kg and ki, the Euclid steps of the gcd and inverse loops; fewer
// run when one modulus divides the other, and a sticky failure goes straight to the
// output without using the unit.
// Reset leaves the merge at x = 0 mod 1 with status ok; no clearing pass.
// The input is ready only in the idle state; a finished word waits in the
// output register while the next input word is taken.
module crt_congruence_merge_core #(
  parameter int unsigned VALUE_BITS = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  crtm_in_if.sink         in_i,
  crtm_out_if.source      out_o
);

  localparam int unsigned W = crtm_pkg::DataW;
  localparam logic [W-1:0] Limit = (64'd1 << VALUE_BITS) - 64'd1;

  crtm_pkg::crtm_state_e  state_q, state_d;
  crtm_pkg::crtm_status_e fail_q, fail_d, st_q, st_d;
  logic                   wait_q, wait_d;
  logic [62:0]            acc_r_q, acc_r_d, acc_m_q, acc_m_d;
  logic                   out_valid_q, out_valid_d;
  logic [62:0]            out_r_q, out_r_d, out_m_q, out_m_d;
  crtm_pkg::crtm_status_e out_st_q, out_st_d;

  logic [W-1:0] r0_q, r0_d, m0_q, m0_d, r1_q, r1_d, m1_q, m1_d;
  logic [W-1:0] s_q, s_d, t_q, t_d, g_q, g_d, dg_q, dg_d, u1_q, u1_d;
  logic [W-1:0] c0_q, c0_d, c1_q, c1_d, q_q, q_d, tmp_q, tmp_d;
  logic         neg_q, neg_d;

  crtm_pkg::crtm_req_t req;
  crtm_pkg::crtm_rsp_t rsp;

  logic         fin;
  logic [W-1:0] r1v, m1v;
  logic [W:0]   dsum;
  crtm_pkg::crtm_status_e fst;

  crtm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign fin = wait_q && rsp.done;

  // Next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    fail_d      = fail_q;
    st_d        = st_q;
    wait_d      = wait_q;
    acc_r_d     = acc_r_q;
    acc_m_d     = acc_m_q;
    out_valid_d = out_valid_q;
    out_r_d     = out_r_q;
    out_m_d     = out_m_q;
    out_st_d    = out_st_q;
    r0_d = r0_q; m0_d = m0_q; r1_d = r1_q; m1_d = m1_q;
    s_d = s_q; t_d = t_q; g_d = g_q; dg_d = dg_q; u1_d = u1_q;
    c0_d = c0_q; c1_d = c1_q; q_d = q_q; tmp_d = tmp_q; neg_d = neg_q;
    r1v  = '0;
    m1v  = '0;
    dsum = '0;
    fst  = st_q;

    if (out_o.ready) out_valid_d = 1'b0;
    if (req.start) wait_d = 1'b1;
    if (fin) wait_d = 1'b0;

    case (state_q)
      crtm_pkg::CRTM_IDLE: begin
        if (in_i.valid) begin
          if (in_i.start_req) begin
            acc_r_d = '0;
            acc_m_d = 63'd1;
            fail_d  = crtm_pkg::CRTM_ST_OK;
            r0_d    = '0;
            m0_d    = 64'd1;
          end else begin
            r0_d = {1'b0, acc_r_q};
            m0_d = {1'b0, acc_m_q};
          end
          if (!in_i.start_req && fail_q != crtm_pkg::CRTM_ST_OK) begin
            st_d    = fail_q;
            state_d = crtm_pkg::CRTM_OUT;
          end else begin
            st_d    = crtm_pkg::CRTM_ST_OK;
            m1_d    = (in_i.modulus == '0) ? 64'd1 : {1'b0, in_i.modulus};
            neg_d   = in_i.residue[63];
            tmp_d   = in_i.residue[63] ? (~in_i.residue + 64'd1) : in_i.residue;
            state_d = crtm_pkg::CRTM_RED;
          end
        end
      end
      crtm_pkg::CRTM_RED: if (fin) begin
        r1v = (neg_q && rsp.rem != '0) ? (m1_q - rsp.rem) : rsp.rem;
        if (m0_q < m1_q) begin
          r0_d = r1v;
          m0_d = m1_q;
          r1_d = r0_q;
          m1_d = m0_q;
        end else begin
          r1_d = r1v;
        end
        state_d = crtm_pkg::CRTM_MOD0;
      end
      crtm_pkg::CRTM_MOD0: if (fin) begin
        if (rsp.rem == '0) begin
          state_d = crtm_pkg::CRTM_CHK0;
        end else begin
          s_d     = m1_q;
          t_d     = rsp.rem;
          state_d = crtm_pkg::CRTM_GCD;
        end
      end
      crtm_pkg::CRTM_CHK0: if (fin) begin
        if (rsp.rem != r1_q) st_d = crtm_pkg::CRTM_ST_NOSOL;
        state_d = crtm_pkg::CRTM_OUT;
      end
      crtm_pkg::CRTM_GCD: begin
        if (t_q == '0) begin
          g_d     = s_q;
          state_d = crtm_pkg::CRTM_DCALC;
        end else if (fin) begin
          s_d = t_q;
          t_d = rsp.rem;
        end
      end
      crtm_pkg::CRTM_DCALC: if (fin) begin
        dsum    = {1'b0, r1_q} + {1'b0, m1_q} - {1'b0, rsp.rem};
        tmp_d   = (dsum >= {1'b0, m1_q}) ? W'(dsum - {1'b0, m1_q}) : dsum[W-1:0];
        state_d = crtm_pkg::CRTM_DG;
      end
      crtm_pkg::CRTM_DG: if (fin) begin
        if (rsp.rem != '0) begin
          st_d    = crtm_pkg::CRTM_ST_NOSOL;
          state_d = crtm_pkg::CRTM_OUT;
        end else begin
          dg_d    = rsp.quo;
          state_d = crtm_pkg::CRTM_U1;
        end
      end
      crtm_pkg::CRTM_U1: if (fin) begin
        u1_d    = rsp.quo;
        state_d = crtm_pkg::CRTM_LIM;
      end
      crtm_pkg::CRTM_LIM: if (fin) begin
        if (m0_q > rsp.quo) begin
          st_d    = crtm_pkg::CRTM_ST_OVF;
          state_d = crtm_pkg::CRTM_OUT;
        end else begin
          state_d = crtm_pkg::CRTM_A0;
        end
      end
      crtm_pkg::CRTM_A0: if (fin) begin
        tmp_d   = rsp.quo;
        state_d = crtm_pkg::CRTM_A1;
      end
      crtm_pkg::CRTM_A1: if (fin) begin
        s_d     = u1_q;
        t_d     = rsp.rem;
        c0_d    = '0;
        c1_d    = 64'd1;
        state_d = crtm_pkg::CRTM_INVQ;
      end
      crtm_pkg::CRTM_INVQ: begin
        if (t_q == '0) begin
          state_d = crtm_pkg::CRTM_DR;
        end else if (fin) begin
          q_d     = rsp.quo;
          s_d     = t_q;
          t_d     = rsp.rem;
          state_d = crtm_pkg::CRTM_INVM;
        end
      end
      crtm_pkg::CRTM_INVM: if (fin) begin
        // Coefficients are kept reduced modulo u1; only the final one matters.
        c0_d    = c1_q;
        c1_d    = (c0_q >= rsp.rem) ? (c0_q - rsp.rem) : (c0_q + u1_q - rsp.rem);
        state_d = crtm_pkg::CRTM_INVQ;
      end
      crtm_pkg::CRTM_DR: if (fin) begin
        tmp_d   = rsp.rem;
        state_d = crtm_pkg::CRTM_TM;
      end
      crtm_pkg::CRTM_TM: if (fin) begin
        tmp_d   = rsp.rem;
        state_d = crtm_pkg::CRTM_RM;
      end
      crtm_pkg::CRTM_RM: if (fin) begin
        r0_d    = r0_q + rsp.rem;
        state_d = crtm_pkg::CRTM_M1;
      end
      crtm_pkg::CRTM_M1: if (fin) begin
        m0_d    = rsp.rem;
        state_d = crtm_pkg::CRTM_OUT;
      end
      crtm_pkg::CRTM_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          fst = st_q;
          if (st_q == crtm_pkg::CRTM_ST_OK && m0_q > Limit) fst = crtm_pkg::CRTM_ST_OVF;
          fail_d      = fst;
          out_st_d    = fst;
          out_valid_d = 1'b1;
          if (fst == crtm_pkg::CRTM_ST_OK) begin
            acc_r_d = r0_q[62:0];
            acc_m_d = m0_q[62:0];
          end else begin
            acc_r_d = '0;
            acc_m_d = '0;
          end
          out_r_d = (fst == crtm_pkg::CRTM_ST_OK) ? r0_q[62:0] : '0;
          out_m_d = (fst == crtm_pkg::CRTM_ST_OK) ? m0_q[62:0] : '0;
          state_d = crtm_pkg::CRTM_IDLE;
        end
      end
      default: state_d = crtm_pkg::CRTM_IDLE;
    endcase
  end

  // Requests to the shared unit and handshake outputs.
  always_comb begin
    req.start = 1'b0;
    req.op    = crtm_pkg::CRTM_OP_DIV;
    req.a     = '0;
    req.b     = 64'd1;
    req.n     = 64'd1;
    case (state_q)
      crtm_pkg::CRTM_RED:   begin req.a = tmp_q; req.b = m1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_MOD0:  begin req.a = m0_q;  req.b = m1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_CHK0:  begin req.a = r0_q;  req.b = m1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_GCD: begin
        req.a = s_q; req.b = t_q; req.start = !wait_q && (t_q != '0);
      end
      crtm_pkg::CRTM_DCALC: begin req.a = r0_q;  req.b = m1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_DG:    begin req.a = tmp_q; req.b = g_q;  req.start = !wait_q; end
      crtm_pkg::CRTM_U1:    begin req.a = m1_q;  req.b = g_q;  req.start = !wait_q; end
      crtm_pkg::CRTM_LIM:   begin req.a = Limit; req.b = u1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_A0:    begin req.a = m0_q;  req.b = g_q;  req.start = !wait_q; end
      crtm_pkg::CRTM_A1:    begin req.a = tmp_q; req.b = u1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_INVQ: begin
        req.a = s_q; req.b = t_q; req.start = !wait_q && (t_q != '0);
      end
      crtm_pkg::CRTM_INVM: begin
        req.op = crtm_pkg::CRTM_OP_MULMOD;
        req.a = c1_q; req.b = q_q; req.n = u1_q; req.start = !wait_q;
      end
      crtm_pkg::CRTM_DR:    begin req.a = dg_q;  req.b = u1_q; req.start = !wait_q; end
      crtm_pkg::CRTM_TM: begin
        req.op = crtm_pkg::CRTM_OP_MULMOD;
        req.a = tmp_q; req.b = c0_q; req.n = u1_q; req.start = !wait_q;
      end
      crtm_pkg::CRTM_RM: begin
        req.op = crtm_pkg::CRTM_OP_MULMOD;
        req.a = m0_q; req.b = tmp_q; req.n = crtm_pkg::Pow63; req.start = !wait_q;
      end
      crtm_pkg::CRTM_M1: begin
        req.op = crtm_pkg::CRTM_OP_MULMOD;
        req.a = m0_q; req.b = u1_q; req.n = crtm_pkg::Pow63; req.start = !wait_q;
      end
      default: req.start = 1'b0;
    endcase
  end

  assign in_i.ready           = (state_q == crtm_pkg::CRTM_IDLE);
  assign out_o.valid          = out_valid_q;
  assign out_o.merged_residue = out_r_q;
  assign out_o.merged_modulus = out_m_q;
  assign out_o.status         = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crtm_pkg::CRTM_IDLE;
      fail_q      <= crtm_pkg::CRTM_ST_OK;
      st_q        <= crtm_pkg::CRTM_ST_OK;
      wait_q      <= 1'b0;
      acc_r_q     <= '0;
      acc_m_q     <= 63'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fail_q      <= fail_d;
      st_q        <= st_d;
      wait_q      <= wait_d;
      acc_r_q     <= acc_r_d;
      acc_m_q     <= acc_m_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_r_q  <= out_r_d;
    out_m_q  <= out_m_d;
    out_st_q <= out_st_d;
    r0_q <= r0_d; m0_q <= m0_d; r1_q <= r1_d; m1_q <= m1_d;
    s_q <= s_d; t_q <= t_d; g_q <= g_d; dg_q <= dg_d; u1_q <= u1_d;
    c0_q <= c0_d; c1_q <= c1_d; q_q <= q_d; tmp_q <= tmp_d; neg_q <= neg_d;
  end

  a_fail_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_q != crtm_pkg::CRTM_ST_OK) |-> (acc_r_q == '0 && acc_m_q == '0))
    else $error("failed merge left a nonzero accumulator");
  a_ok_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fail_q == crtm_pkg::CRTM_ST_OK) |-> (acc_m_q != '0 && acc_r_q < acc_m_q))
    else $error("accumulated residue not below modulus");
  a_wait_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wait_q |-> (state_q != crtm_pkg::CRTM_IDLE && state_q != crtm_pkg::CRTM_OUT))
    else $error("waiting on the unit outside an operation state");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("result word dropped before it was taken");

endmodule

@@ tb/crtm_merge_checker.sv @@
// Checker that predicts the merged congruence for every word and compares the results.
module crtm_merge_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  crtm_in_if     in_ch,
  crtm_out_if    out_ch,
  output int     fail_cnt_o,
  output int     pending_o
);

  localparam logic [63:0] Lim63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [62:0]            residue;
    logic [62:0]            modulus;
    crtm_pkg::crtm_status_e status;
  } merge_res_t;

  merge_res_t             expected_q[$];
  logic [63:0]            sys_residue;
  logic [63:0]            sys_modulus;
  crtm_pkg::crtm_status_e sys_status;
  int                     fail_cnt;
  int                     pending;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending;

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] mulmod64(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] acc;
    acc = 0;
    a = a % n;
    while (b != 0) begin
      if (b[0]) begin
        acc = acc + a;
        if (acc >= n) acc = acc - n;
      end
      a = a + a;
      if (a >= n) a = a - n;
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic logic [63:0] invmod64(logic [63:0] a, logic [63:0] n);
    longint s, t, c0, c1, q, tmp;
    s  = longint'(n);
    t  = longint'(a % n);
    c0 = 0;
    c1 = 1;
    while (t != 0) begin
      q   = s / t;
      s   = s - t * q;
      c0  = c0 - c1 * q;
      tmp = s;  s  = t;  t  = tmp;
      tmp = c0; c0 = c1; c1 = tmp;
    end
    if (c0 < 0) c0 = c0 + longint'(n);
    return 64'(c0);
  endfunction

  // Folds one congruence into the running system and returns the reported word.
  function automatic merge_res_t merge_word(logic [63:0] raw, logic [62:0] mod_in, logic start);
    merge_res_t  res;
    logic [63:0] m1, r1, r0, m0, t, g, d, u1, im, mag;
    if (start) begin
      sys_residue = 0;
      sys_modulus = 1;
      sys_status  = crtm_pkg::CRTM_ST_OK;
    end
    if (sys_status == crtm_pkg::CRTM_ST_OK) begin
      m1 = {1'b0, mod_in};
      if (m1 == 0) m1 = 1;
      if (!raw[63]) begin
        r1 = raw % m1;
      end else begin
        mag = ~raw + 1;
        t   = mag % m1;
        r1  = (t != 0) ? m1 - t : 0;
      end
      r0 = sys_residue;
      m0 = sys_modulus;
      if (m0 < m1) begin
        t = r0; r0 = r1; r1 = t;
        t = m0; m0 = m1; m1 = t;
      end
      if (m0 % m1 == 0) begin
        if (r0 % m1 != r1) sys_status = crtm_pkg::CRTM_ST_NOSOL;
      end else begin
        g = gcd64(m0, m1);
        d = (r1 + m1 - (r0 % m1)) % m1;
        if (d % g != 0) begin
          sys_status = crtm_pkg::CRTM_ST_NOSOL;
        end else begin
          u1 = m1 / g;
          if (m0 > Lim63 / u1) begin
            sys_status = crtm_pkg::CRTM_ST_OVF;
          end else begin
            im = invmod64((m0 / g) % u1, u1);
            t  = mulmod64((d / g) % u1, im, u1);
            r0 = r0 + t * m0;
            m0 = m0 * u1;
          end
        end
      end
      if (sys_status == crtm_pkg::CRTM_ST_OK && m0 > Lim63) sys_status = crtm_pkg::CRTM_ST_OVF;
      if (sys_status == crtm_pkg::CRTM_ST_OK) begin
        sys_residue = r0;
        sys_modulus = m0;
      end else begin
        sys_residue = 0;
        sys_modulus = 0;
      end
    end
    res.residue = (sys_status == crtm_pkg::CRTM_ST_OK) ? sys_residue[62:0] : '0;
    res.modulus = (sys_status == crtm_pkg::CRTM_ST_OK) ? sys_modulus[62:0] : '0;
    res.status  = sys_status;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    merge_res_t got, want;
    if (!rst_ni) begin
      sys_residue = 0;
      sys_modulus = 1;
      sys_status  = crtm_pkg::CRTM_ST_OK;
      fail_cnt    = 0;
      expected_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(merge_word(in_ch.residue, in_ch.modulus, in_ch.start_req));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.residue = out_ch.merged_residue;
        got.modulus = out_ch.merged_modulus;
        got.status  = crtm_pkg::crtm_status_e'(out_ch.status);
        if (expected_q.size() == 0) begin
          $error("result word with no expected word: residue %0d modulus %0d status %0d",
                 got.residue, got.modulus, got.status);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (got.residue !== want.residue) begin
            $error("merged_residue: expected %0d, actual %0d", want.residue, got.residue);
            fail_cnt++;
          end
          if (got.modulus !== want.modulus) begin
            $error("merged_modulus: expected %0d, actual %0d", want.modulus, got.modulus);
            fail_cnt++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_cnt++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top: drives congruence words into the merge core and gives the verdict.
module tb_top;

  localparam longint CycleLimit = 64'd100_000_000;
  localparam int     RandWords  = 900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  longint cycle_cnt = 0;
  int   burst_left = 0;
  int   stall_mode = 0;

  crtm_in_if  in_ch ();
  crtm_out_if out_ch ();

  crt_congruence_merge_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  crtm_merge_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.residue = '0;
    in_ch.modulus = '0;
    in_ch.start_req = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The receiver switches between always ready, light stalls and heavy stalls.
  always @(posedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sends one word; between bursts the valid line drops for a random gap.
  task automatic send_word(logic [63:0] res, logic [62:0] modv, logic start);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 40);
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.residue   <= res;
    in_ch.modulus   <= modv;
    in_ch.start_req <= start;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [63:0] x, m, r;
    int          bits, seq_len, sent;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: field extremes, zero modulus, conflicts, sticky failure, overflow.
    send_word(64'd5, 63'd0, 1'b1);
    send_word(64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(64'h8000_0000_0000_0000, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_word(-64'sd1, 63'd7, 1'b1);
    send_word(64'd2, 63'd5, 1'b0);
    send_word(64'd3, 63'd4, 1'b0);
    send_word(64'd1, 63'd6, 1'b0);
    send_word(64'd4, 63'd6, 1'b0);
    send_word(64'd0, 63'd1, 1'b0);
    send_word(64'h8000_0000_0000_0000, 63'd3, 1'b1);
    send_word(64'd1, 63'd4, 1'b0);
    send_word(64'd3, 63'd6, 1'b0);
    send_word(64'd0, 63'd2, 1'b0);
    send_word(64'd1, 63'h4000_0000_0000_0001, 1'b1);
    send_word(64'd0, 63'd3, 1'b0);
    send_word(64'd0, 63'd5, 1'b0);
    send_word(-64'sd100, 63'd9, 1'b1);
    send_word(64'd7, 63'd12, 1'b0);
    send_word(64'd0, 63'd0, 1'b0);
    drain();

    sent = 0;
    while (sent < RandWords) begin
      if ($urandom_range(0, 9) < 8) begin
        // System built around one hidden solution; some residues are shifted by the modulus or replaced at random.
        x = rand64() & 64'h7FFF_FFFF_FFFF_FFFF;
        seq_len = $urandom_range(1, 8);
        for (int i = 0; i < seq_len; i++) begin
          bits = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 63) : $urandom_range(1, 20);
          m = (rand64() & ((64'd1 << bits) - 1)) & 64'h7FFF_FFFF_FFFF_FFFF;
          if (m == 0) m = 1;
          r = x % m;
          case ($urandom_range(0, 3))
            0: r = r - m;
            1: if ($urandom_range(0, 3) == 0) r = rand64();
            default: ;
          endcase
          send_word(r, m[62:0], i == 0);
          sent++;
        end
      end else begin
        send_word(rand64(), 63'(rand64()), 1'($urandom_range(0, 1)));
        sent++;
      end
      if (sent >= RandWords / 2 && sent < RandWords / 2 + 9) drain();
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
